@@ rtl/assert_macros.svh @@
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ssd assertion failed");

// next-cycle implication, disabled while in reset
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ssd assertion failed");

`endif

@@ rtl/ssd_pkg.sv @@
package ssd_pkg;

    localparam int MODE_W = 2;
    localparam int SID_W = 4;
    localparam int SEED_W = 64;
    localparam int STREAM_COUNT_DEF = 16;

    localparam logic [MODE_W-1:0] MODE_DERIVE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SET = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

    localparam logic [SEED_W-1:0] DEFAULT_MASTER = 64'h2006200420062004;
    localparam logic [SEED_W-1:0] GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [SEED_W-1:0] SALT = 64'h0211202502112025;
    localparam logic [SEED_W-1:0] MIX_K1 = 64'hff51afd7ed558ccd;
    localparam logic [SEED_W-1:0] MIX_K2 = 64'hc4ceb9fe1a85ec53;
    localparam int MIX_SHIFT = 33;

    typedef enum logic [2:0] {
        SRC_IDX,
        SRC_SID,
        SRC_MASTER,
        SRC_FINAL,
        SRC_SALT
    } t_mix_src;

    typedef enum logic [1:0] {
        B_HOLD,
        B_MASTER,
        B_OVR,
        B_MIX
    } t_base_sel;

    typedef enum logic [2:0] {
        RES_HOLD,
        RES_SEED,
        RES_MASTER_W,
        RES_MIX,
        RES_BASE,
        RES_ZERO
    } t_res_sel;

    typedef struct packed {
        logic      latch;
        logic      mix_start;
        t_mix_src  mix_src;
        logic      a_load;
        t_base_sel b_sel;
        t_res_sel  res_sel;
        logic      master_write;
        logic      ovr_write;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              is_master;
        logic              ovr_hit;
        logic              seed_zero;
        logic              mix_done;
    } t_status;

endpackage

@@ rtl/ssd_in_if.sv @@
interface ssd_in_if;
    logic                         valid;
    logic                         ready;
    logic [ssd_pkg::MODE_W-1:0]   mode;
    logic [ssd_pkg::SID_W-1:0]    stream_id;
    logic [ssd_pkg::SEED_W-1:0]   substream_index;
    logic [ssd_pkg::SEED_W-1:0]   seed_value;

    modport source (output valid, mode, stream_id, substream_index, seed_value, input ready);
    modport sink (input valid, mode, stream_id, substream_index, seed_value, output ready);
endinterface

@@ rtl/ssd_out_if.sv @@
interface ssd_out_if;
    logic                         valid;
    logic                         ready;
    logic [ssd_pkg::SEED_W-1:0]   seed_out;

    modport source (output valid, seed_out, input ready);
    modport sink (input valid, seed_out, output ready);
endinterface

@@ rtl/ssd_mixer.sv @@
module ssd_mixer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ssd_pkg::SEED_W-1:0] i_value,
    output logic                       o_done,
    output logic [ssd_pkg::SEED_W-1:0] o_result
);
    import ssd_pkg::*;
    `include "assert_macros.svh"

    logic              r_busy;
    logic              r_done;
    logic [2:0]        r_step;
    logic [SEED_W-1:0] r_v;
    logic [SEED_W-1:0] r_acc;

    logic [31:0]       w_mul_a;
    logic [31:0]       w_mul_b;
    logic [63:0]       w_prod;
    logic [SEED_W-1:0] w_k;

    // three 32x32 partial products give the low 64 bits of each multiply
    assign w_k = r_step[2] ? MIX_K2 : MIX_K1;
    assign w_mul_a = (r_step[1:0] == 2'd1) ? r_v[63:32] : r_v[31:0];
    assign w_mul_b = (r_step[1:0] == 2'd2) ? w_k[63:32] : w_k[31:0];
    assign w_prod = {32'd0, w_mul_a} * {32'd0, w_mul_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_v <= i_value ^ (i_value >> MIX_SHIFT);
                r_busy <= 1'b1;
                r_step <= 3'd0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                case (r_step[1:0])
                    2'd0: r_acc <= w_prod;
                    2'd1, 2'd2: r_acc <= r_acc + {w_prod[31:0], 32'd0};
                    default: r_v <= r_acc ^ (r_acc >> MIX_SHIFT);
                endcase
                if (r_step == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_result = r_v;

    `SSD_ASSERT_IMPL(a_no_restart, i_clk, i_rst_n, i_start, !r_busy)
    `SSD_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, r_done, !r_busy)
    `SSD_ASSERT_NEXT(a_last_step_done, i_clk, i_rst_n, r_busy && (r_step == 3'd7) && !i_start,
        r_done && !r_busy)

endmodule

@@ rtl/ssd_datapath.sv @@
module ssd_datapath #(
    parameter int STREAM_COUNT = ssd_pkg::STREAM_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ssd_pkg::SID_W-1:0]  i_cfg_wdata,
    input  logic [ssd_pkg::MODE_W-1:0] i_mode,
    input  logic [ssd_pkg::SID_W-1:0]  i_stream_id,
    input  logic [ssd_pkg::SEED_W-1:0] i_substream_index,
    input  logic [ssd_pkg::SEED_W-1:0] i_seed_value,
    output logic [ssd_pkg::SEED_W-1:0] o_seed_out,
    input  ssd_pkg::t_cmd              i_cmd,
    output ssd_pkg::t_status           o_status
);
    import ssd_pkg::*;

    localparam int IDX_W = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;

    logic [SID_W-1:0]        r_master_id;
    logic [SEED_W-1:0]       r_master;
    logic [STREAM_COUNT-1:0] r_valid;
    logic [SEED_W-1:0]       r_ovr [STREAM_COUNT];
    logic [SEED_W-1:0]       r_rdata;

    logic [MODE_W-1:0]       r_mode;
    logic [SID_W-1:0]        r_sid;
    logic [SEED_W-1:0]       r_idx;
    logic [SEED_W-1:0]       r_seed;
    logic [SEED_W-1:0]       r_a;
    logic [SEED_W-1:0]       r_b;
    logic [SEED_W-1:0]       r_res;
    logic [SEED_W-1:0]       r_out;

    logic [SEED_W-1:0]       n_res;
    logic [SEED_W-1:0]       n_master;
    logic [SEED_W-1:0]       w_mix_in;
    logic [SEED_W-1:0]       w_mix_res;
    logic                    w_mix_done;
    logic [IDX_W-1:0]        w_addr;
    logic                    w_in_range;
    logic                    w_seed_zero;

    assign w_addr = IDX_W'(r_sid);
    assign w_in_range = (32'(r_sid) < STREAM_COUNT);
    assign w_seed_zero = (r_seed == '0);
    assign n_master = w_seed_zero ? DEFAULT_MASTER : r_seed;

    always_comb begin
        case (i_cmd.mix_src)
            SRC_IDX: w_mix_in = r_idx + GOLDEN;
            SRC_SID: w_mix_in = SEED_W'(r_sid) + GOLDEN;
            SRC_MASTER: w_mix_in = r_master ^ w_mix_res;
            SRC_FINAL: w_mix_in = r_b + r_a;
            SRC_SALT: w_mix_in = SEED_W'(r_sid) ^ SALT;
            default: w_mix_in = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.res_sel)
            RES_SEED: n_res = r_seed;
            RES_MASTER_W: n_res = n_master;
            RES_MIX: n_res = w_mix_res;
            RES_BASE: n_res = r_b;
            RES_ZERO: n_res = '0;
            default: n_res = r_res;
        endcase
    end

    ssd_mixer u_mixer (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.mix_start),
        .i_value(w_mix_in),
        .o_done(w_mix_done),
        .o_result(w_mix_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_id <= '0;
            r_master <= DEFAULT_MASTER;
            r_valid <= '0;
        end else begin
            if (i_cfg_we) begin
                r_master_id <= i_cfg_wdata;
            end
            if (i_cmd.master_write) begin
                r_master <= n_master;
            end
            if (i_cmd.ovr_write && w_in_range) begin
                r_valid[w_addr] <= 1'b1;
            end
        end
    end

    // override store
    always_ff @(posedge i_clk) begin
        if (i_cmd.ovr_write && w_in_range) begin
            r_ovr[w_addr] <= n_res;
        end
        r_rdata <= r_ovr[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= i_mode;
            r_sid <= i_stream_id;
            r_idx <= i_substream_index;
            r_seed <= i_seed_value;
        end
        if (i_cmd.a_load) begin
            r_a <= w_mix_res;
        end
        case (i_cmd.b_sel)
            B_MASTER: r_b <= r_master;
            B_OVR: r_b <= r_rdata;
            B_MIX: r_b <= w_mix_res;
            default: r_b <= r_b;
        endcase
        r_res <= n_res;
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_seed_out = r_out;
    assign o_status.mode = r_mode;
    assign o_status.is_master = (r_sid == r_master_id);
    assign o_status.ovr_hit = w_in_range && r_valid[w_addr];
    assign o_status.seed_zero = w_seed_zero;
    assign o_status.mix_done = w_mix_done;

endmodule

@@ rtl/ssd_ctrl.sv @@
module ssd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output ssd_pkg::t_cmd    o_cmd,
    input  ssd_pkg::t_status i_status
);
    import ssd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_W_IDX,
        S_BASE,
        S_W_SID,
        S_W_MASTER,
        S_AFTER_BASE,
        S_W_FINAL,
        S_W_SALT,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.mix_src = SRC_IDX;
        o_cmd.b_sel = B_HOLD;
        o_cmd.res_sel = RES_HOLD;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_status.mode)
                    MODE_DERIVE: begin
                        o_cmd.mix_start = 1'b1;
                        o_cmd.mix_src = SRC_IDX;
                        n_state = S_W_IDX;
                    end
                    MODE_SET: begin
                        if (i_status.is_master) begin
                            o_cmd.master_write = 1'b1;
                            o_cmd.res_sel = RES_MASTER_W;
                            n_state = S_DONE;
                        end else if (!i_status.seed_zero) begin
                            o_cmd.res_sel = RES_SEED;
                            o_cmd.ovr_write = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.mix_start = 1'b1;
                            o_cmd.mix_src = SRC_SALT;
                            n_state = S_W_SALT;
                        end
                    end
                    MODE_READ: n_state = S_BASE;
                    default: begin
                        o_cmd.res_sel = RES_ZERO;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_W_IDX: begin
                if (i_status.mix_done) begin
                    o_cmd.a_load = 1'b1;
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                if (i_status.is_master) begin
                    o_cmd.b_sel = B_MASTER;
                    n_state = S_AFTER_BASE;
                end else if (i_status.ovr_hit) begin
                    o_cmd.b_sel = B_OVR;
                    n_state = S_AFTER_BASE;
                end else begin
                    o_cmd.mix_start = 1'b1;
                    o_cmd.mix_src = SRC_SID;
                    n_state = S_W_SID;
                end
            end
            S_W_SID: begin
                if (i_status.mix_done) begin
                    o_cmd.mix_start = 1'b1;
                    o_cmd.mix_src = SRC_MASTER;
                    n_state = S_W_MASTER;
                end
            end
            S_W_MASTER: begin
                if (i_status.mix_done) begin
                    o_cmd.b_sel = B_MIX;
                    n_state = S_AFTER_BASE;
                end
            end
            S_AFTER_BASE: begin
                if (i_status.mode == MODE_DERIVE) begin
                    o_cmd.mix_start = 1'b1;
                    o_cmd.mix_src = SRC_FINAL;
                    n_state = S_W_FINAL;
                end else begin
                    o_cmd.res_sel = RES_BASE;
                    n_state = S_DONE;
                end
            end
            S_W_FINAL: begin
                if (i_status.mix_done) begin
                    o_cmd.res_sel = RES_MIX;
                    n_state = S_DONE;
                end
            end
            S_W_SALT: begin
                if (i_status.mix_done) begin
                    o_cmd.res_sel = RES_MIX;
                    o_cmd.ovr_write = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/stream_seed_derivation_top.sv @@
// Stream seed derivation: each input item gives exactly one seed_out item. Mode 0 derives the
// final seed for (stream_id, substream_index), mode 1 stores a stream seed and echoes it, mode 2
// returns the stream base seed, mode 3 returns zero. One item is worked on at a time; the next is
// taken once the current result sits in the output register, even while that result still waits.
// Results come from passes through the shared 64-bit mixer; every 64-bit multiply in a pass is
// built from three products on one 32x32 multiplier. Mode 0 needs two or four passes, mode 2
// zero or two passes, mode 1 one pass for an override write of zero and otherwise none.
// master_stream_id is written through i_cfg_we and i_cfg_wdata; the user must do so only while
// the block is idle, which the block itself does not enforce. Stream ids at or above STREAM_COUNT
// have no override storage and use the mixed master seed unless they are the master stream.
module stream_seed_derivation_top #(
    parameter int STREAM_COUNT = ssd_pkg::STREAM_COUNT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [ssd_pkg::SID_W-1:0] i_cfg_wdata,
    ssd_in_if.sink                    i_in,
    ssd_out_if.source                 o_out
);
    import ssd_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    ssd_ctrl u_ctrl (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid),
        .o_in_ready(i_in.ready),
        .o_out_valid(o_out.valid),
        .i_out_ready(o_out.ready),
        .o_cmd(w_cmd),
        .i_status(w_status)
    );

    ssd_datapath #(
        .STREAM_COUNT(STREAM_COUNT)
    ) u_datapath (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_mode(i_in.mode),
        .i_stream_id(i_in.stream_id),
        .i_substream_index(i_in.substream_index),
        .i_seed_value(i_in.seed_value),
        .o_seed_out(o_out.seed_out),
        .i_cmd(w_cmd),
        .o_status(w_status)
    );

endmodule

@@ test/testbench.sv @@
module testbench;
    import ssd_pkg::*;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
    localparam int NSTREAMS = STREAM_COUNT_DEF;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;
    localparam int LONG_STALL = 300;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SID_W-1:0]  stream_id;
        logic [SEED_W-1:0] substream_index;
        logic [SEED_W-1:0] seed_value;
    } seed_req_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [SID_W-1:0] i_cfg_wdata;

    ssd_in_if in_ch();
    ssd_out_if out_ch();

    stream_seed_derivation_top dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in(in_ch),
        .o_out(out_ch)
    );

    // expected block state
    logic [SEED_W-1:0] exp_master_seed;
    logic [SID_W-1:0]  exp_master_sid;
    bit                exp_ovr_valid [NSTREAMS];
    logic [SEED_W-1:0] exp_ovr_value [NSTREAMS];

    seed_req_t         request_q [$];
    logic [SEED_W-1:0] pending_seeds [$];
    seed_req_t         cur_req;
    logic [SEED_W-1:0] want_seed;

    int  issued_total = 0;
    int  accepted_total = 0;
    int  results_total = 0;
    int  errors = 0;
    int  send_gap = 0;
    int  recv_stall = 0;
    int  idle_cycles = 0;
    bit  idle_en = 1'b1;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [SEED_W-1:0] fmix64(input logic [SEED_W-1:0] v);
        logic [SEED_W-1:0] x;
        x = v;
        x = x ^ (x >> MIX_SHIFT);
        x = x * MIX_K1;
        x = x ^ (x >> MIX_SHIFT);
        x = x * MIX_K2;
        x = x ^ (x >> MIX_SHIFT);
        return x;
    endfunction

    function automatic logic [SEED_W-1:0] stream_base(input logic [SID_W-1:0] sid);
        logic [SEED_W-1:0] sid_w;
        sid_w = {{(SEED_W-SID_W){1'b0}}, sid};
        if (sid == exp_master_sid)
            return exp_master_seed;
        if (sid_w < NSTREAMS && exp_ovr_valid[sid])
            return exp_ovr_value[sid];
        return fmix64(exp_master_seed ^ fmix64(sid_w + GOLDEN));
    endfunction

    // returns the seed for one request and updates the expected state
    function automatic logic [SEED_W-1:0] derive_seed(input seed_req_t r);
        logic [SEED_W-1:0] res;
        logic [SEED_W-1:0] sid_w;
        sid_w = {{(SEED_W-SID_W){1'b0}}, r.stream_id};
        res = '0;
        case (r.mode)
            MODE_DERIVE: begin
                res = fmix64(stream_base(r.stream_id) + fmix64(r.substream_index + GOLDEN));
            end
            MODE_SET: begin
                if (r.stream_id == exp_master_sid) begin
                    exp_master_seed = (r.seed_value != 0) ? r.seed_value : DEFAULT_MASTER;
                    res = exp_master_seed;
                end else begin
                    res = (r.seed_value != 0) ? r.seed_value : fmix64(sid_w ^ SALT);
                    if (sid_w < NSTREAMS) begin
                        exp_ovr_value[r.stream_id] = res;
                        exp_ovr_valid[r.stream_id] = 1'b1;
                    end
                end
            end
            MODE_READ: begin
                res = stream_base(r.stream_id);
            end
            default: begin
                res = '0;
            end
        endcase
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [SEED_W-1:0] rand_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    task automatic push_req(input logic [MODE_W-1:0] mode, input logic [SID_W-1:0] sid,
                            input logic [SEED_W-1:0] idx, input logic [SEED_W-1:0] seed);
        seed_req_t r;
        r.mode = mode;
        r.stream_id = sid;
        r.substream_index = idx;
        r.seed_value = seed;
        request_q.push_back(r);
        issued_total++;
    endtask

    task automatic push_random(input int n, input bit with_idle);
        logic [MODE_W-1:0] mode;
        logic [SID_W-1:0]  sid;
        logic [SEED_W-1:0] seed;
        int r;
        idle_en = with_idle;
        repeat (n) begin
            r = $urandom_range(0, 19);
            if (r < 8)
                mode = MODE_DERIVE;
            else if (r < 13)
                mode = MODE_SET;
            else if (r < 18)
                mode = MODE_READ;
            else
                mode = MODE_NONE;
            sid = ($urandom_range(0, 4) == 0) ? exp_master_sid : SID_W'($urandom_range(0, 15));
            seed = ($urandom_range(0, 4) == 0) ? '0 : rand_word();
            push_req(mode, sid, rand_word(), seed);
        end
    endtask

    task automatic wait_drained();
        while (accepted_total != issued_total || pending_seeds.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_master_stream(input logic [SID_W-1:0] sid);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= sid;
        exp_master_sid = sid;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                pending_seeds.push_back(derive_seed(cur_req));
                accepted_total++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (request_q.size() > 0) begin
                    cur_req = request_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.mode <= cur_req.mode;
                    in_ch.stream_id <= cur_req.stream_id;
                    in_ch.substream_index <= cur_req.substream_index;
                    in_ch.seed_value <= cur_req.seed_value;
                    send_gap = (idle_en && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // seed monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_total++;
                if (pending_seeds.size() == 0) begin
                    $display("%0t unexpected seed: expected none actual %h",
                             $time, out_ch.seed_out);
                    errors++;
                end else begin
                    want_seed = pending_seeds.pop_front();
                    if (want_seed !== out_ch.seed_out) begin
                        $display("%0t seed_out mismatch: expected %h actual %h",
                                 $time, want_seed, out_ch.seed_out);
                        errors++;
                    end
                end
                // long hold-off so the block backs up into its input
                if (results_total == 200 || results_total == 650)
                    recv_stall = LONG_STALL;
                else if (idle_en && $urandom_range(0, 3) == 0)
                    recv_stall = pick_gap();
            end else if (idle_en && recv_stall == 0 && $urandom_range(0, 15) == 0) begin
                recv_stall = pick_gap();
            end
            if (recv_stall > 0) begin
                recv_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t timeout with %0d seeds outstanding", $time, pending_seeds.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = '0;
        in_ch.stream_id = '0;
        in_ch.substream_index = '0;
        in_ch.seed_value = '0;
        out_ch.ready = 1'b0;
        exp_master_seed = DEFAULT_MASTER;
        exp_master_sid = '0;
        for (int i = 0; i < NSTREAMS; i++) begin
            exp_ovr_valid[i] = 1'b0;
            exp_ovr_value[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: master stream at its reset id 0
        push_req(MODE_DERIVE, 4'd0, '0, '0);
        push_req(MODE_DERIVE, 4'd5, '1, '0);
        push_req(MODE_READ, 4'd0, '0, '1);
        push_req(MODE_READ, 4'd7, '1, '0);
        push_req(MODE_SET, 4'd0, '0, '0);
        push_req(MODE_SET, 4'd0, '0, '1);
        push_req(MODE_DERIVE, 4'd0, 64'd1, '0);
        push_req(MODE_READ, 4'd9, '0, '0);
        // zero write to a normal stream takes the salted value
        push_req(MODE_SET, 4'd3, '1, '0);
        push_req(MODE_READ, 4'd3, '0, '0);
        push_req(MODE_DERIVE, 4'd3, '0, '0);
        push_req(MODE_SET, 4'd15, '0, 64'h8000_0000_0000_0001);
        push_req(MODE_READ, 4'd15, '0, '0);
        push_req(MODE_DERIVE, 4'd15, '1, '1);
        push_req(MODE_SET, 4'd1, '0, 64'd1);
        push_req(MODE_DERIVE, 4'd1, 64'h5555_5555_5555_5555, '0);
        push_req(MODE_NONE, 4'd9, '1, '1);
        push_req(MODE_NONE, 4'd0, '0, '0);
        push_req(MODE_SET, 4'd0, '0, 64'd1);
        push_req(MODE_DERIVE, 4'd2, 64'hAAAA_AAAA_AAAA_AAAA, '0);
        push_req(MODE_READ, 4'd15, '0, '0);
        push_req(MODE_SET, 4'd0, '0, '0);

        // stream 15 holds an override that must be ignored while it is master
        set_master_stream(4'd15);
        push_req(MODE_READ, 4'd15, '0, '0);
        push_req(MODE_SET, 4'd15, '0, '0);
        push_req(MODE_READ, 4'd0, '0, '0);
        push_random(200, 1'b1);

        set_master_stream(4'd0);
        push_random(200, 1'b0);

        set_master_stream(4'd7);
        push_random(200, 1'b1);

        set_master_stream(SID_W'($urandom_range(1, 14)));
        push_random(200, 1'b1);

        set_master_stream(4'd15);
        push_random(130, 1'b1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ssd_pkg.sv
rtl/ssd_in_if.sv
rtl/ssd_out_if.sv
rtl/ssd_mixer.sv
rtl/ssd_datapath.sv
rtl/ssd_ctrl.sv
rtl/stream_seed_derivation_top.sv
test/testbench.sv
